/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the sequencer top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/core/sss_pkg.sv */
// ----------------------------------------------------------------------------
// sss_pkg
// Types and codes shared by the step sequencer modules.
// ----------------------------------------------------------------------------
package sss_pkg;

    // Request codes
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_TICK   = 3'd2;
    localparam logic [2:0] REQ_SAMPLE = 3'd3;
    localparam logic [2:0] REQ_QUIT   = 3'd4;

    // Table word selects
    localparam logic [2:0] SEL_JUMP   = 3'd0;
    localparam logic [2:0] SEL_MASK   = 3'd1;
    localparam logic [2:0] SEL_TARGET = 3'd2;
    localparam logic [2:0] SEL_DUR    = 3'd3;
    localparam logic [2:0] SEL_DRIVE  = 3'd4;
    localparam logic [2:0] SEL_DIV    = 3'd5;

    // Result kinds
    localparam logic [1:0] KIND_RECORD  = 2'd0;
    localparam logic [1:0] KIND_APPLIED = 2'd1;
    localparam logic [1:0] KIND_FINISH  = 2'd2;

    // Trigger logic codes
    localparam logic [1:0] LOGIC_NONE = 2'd0;
    localparam logic [1:0] LOGIC_OR   = 2'd1;

    // Special jump codes
    localparam logic signed [15:0] JMP_MINUS_ONE = -16'sd1;
    localparam logic signed [15:0] JMP_MINUS_TWO = -16'sd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STEP_TOTAL   = 2'd0;
    localparam logic [1:0] CFG_REPEAT_TOTAL = 2'd1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  entry_addr;
        logic [2:0]  word_sel;
        logic [31:0] write_data;
        logic [31:0] di_sample;
    } t_req;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [4:0]  step_number;
        logic        was_triggered;
        logic [15:0] elapsed_ms;
        logic [31:0] di_snapshot;
        logic [31:0] drive_word;
        logic        drive_valid;
        logic [31:0] freq_div;
        logic        last;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_ENTER,
        S_APPLY
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic eval;
        logic enter;
        logic apply;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic running;
        logic step_end;
        logic enter_ok;
    } t_stat;

endpackage

/* rtl/core/sss_ram.sv */
// ----------------------------------------------------------------------------
// sss_ram
// Single write port, single registered read port RAM.
// ----------------------------------------------------------------------------
module sss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/sss_ctrl.sv */
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer controller: accepts request words and steps the datapath
// through evaluate, enter and apply phases.
// ----------------------------------------------------------------------------
module sss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_req_type,
    input  sss_pkg::t_stat i_stat,
    output sss_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import sss_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_busy      = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.take = 1'b1;
                    if (i_req_type == REQ_START) begin
                        n_state = S_ENTER;
                    end else if ((i_req_type == REQ_TICK || i_req_type == REQ_SAMPLE)
                                 && i_stat.running) begin
                        n_state = S_EVAL;
                    end
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_stat.step_end ? S_ENTER : S_IDLE;
            end
            S_ENTER: begin
                o_cmd.enter = 1'b1;
                n_state = i_stat.enter_ok ? S_APPLY : S_IDLE;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/core/sss_dpath.sv */
// ----------------------------------------------------------------------------
// sss_dpath
// Sequencer datapath: step table, step and repeat state, timing, trigger
// match, jump decode and the result register.
// ----------------------------------------------------------------------------
module sss_dpath #(
    parameter int STEP_DEPTH = 16,
    parameter int DI_COUNT   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sss_pkg::t_req  i_req,
    input  sss_pkg::t_cmd  i_cmd,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data,
    output sss_pkg::t_stat o_stat,
    output logic          o_done,
    output sss_pkg::t_res  o_res
);
    import sss_pkg::*;

    localparam int IW = $clog2(STEP_DEPTH);

    logic [4:0]          r_step_total;
    logic [7:0]          r_repeat_total;
    logic [IW-1:0]       r_cur;
    logic [7:0]          r_repeats;
    logic                r_running;
    logic [15:0]         r_elapsed;
    logic [31:0]         r_last_sample;
    logic                r_is_tick;
    logic [15:0]         r_next;
    logic                r_done;
    t_res                r_res;
    t_res                n_res;

    logic [IW-1:0]       w_raddr;
    logic [15:0]         w_addr16;
    logic                w_wr_ok;
    logic [17:0]         w_rd_jump;
    logic [DI_COUNT-1:0] w_rd_mask;
    logic [DI_COUNT-1:0] w_rd_targ;
    logic [15:0]         w_rd_dur;
    logic [31:0]         w_rd_drive;
    logic [31:0]         w_rd_div;
    logic [15:0]         w_total;
    logic [DI_COUNT-1:0] w_hits;
    logic                w_trig;
    logic                w_timeout;
    logic                w_end;
    logic signed [15:0]  w_jump;
    logic [15:0]         w_next;
    logic                w_in_range;
    logic                w_can_wrap;
    logic                w_enter_ok;
    logic [15:0]         w_cur16;

    assign w_addr16 = 16'(i_req.entry_addr);
    assign w_cur16  = 16'(r_cur);
    assign w_wr_ok  = i_cmd.take && (i_req.req_type == REQ_WRITE) && !r_running
                      && (w_addr16 < 16'(STEP_DEPTH));
    assign w_total  = (16'(r_step_total) > 16'(STEP_DEPTH)) ? 16'(STEP_DEPTH)
                                                            : 16'(r_step_total);
    assign w_in_range = r_next < w_total;
    assign w_can_wrap = (r_repeat_total != 8'd0) && (r_repeats != 8'd0)
                        && (w_total != 16'd0);
    assign w_enter_ok = w_in_range || w_can_wrap;

    // Read the current step, or the step being entered
    assign w_raddr = i_cmd.enter ? (w_in_range ? r_next[IW-1:0] : '0) : r_cur;

    // Step table, one RAM per word
    sss_ram #(.WIDTH(18), .DEPTH(STEP_DEPTH)) u_ram_jump (
        .i_clk(i_clk), .i_we(w_wr_ok && i_req.word_sel == SEL_JUMP),
        .i_waddr(w_addr16[IW-1:0]), .i_wdata(i_req.write_data[17:0]),
        .i_raddr(w_raddr), .o_rdata(w_rd_jump)
    );
    sss_ram #(.WIDTH(DI_COUNT), .DEPTH(STEP_DEPTH)) u_ram_mask (
        .i_clk(i_clk), .i_we(w_wr_ok && i_req.word_sel == SEL_MASK),
        .i_waddr(w_addr16[IW-1:0]), .i_wdata(i_req.write_data[DI_COUNT-1:0]),
        .i_raddr(w_raddr), .o_rdata(w_rd_mask)
    );
    sss_ram #(.WIDTH(DI_COUNT), .DEPTH(STEP_DEPTH)) u_ram_targ (
        .i_clk(i_clk), .i_we(w_wr_ok && i_req.word_sel == SEL_TARGET),
        .i_waddr(w_addr16[IW-1:0]), .i_wdata(i_req.write_data[DI_COUNT-1:0]),
        .i_raddr(w_raddr), .o_rdata(w_rd_targ)
    );
    sss_ram #(.WIDTH(16), .DEPTH(STEP_DEPTH)) u_ram_dur (
        .i_clk(i_clk), .i_we(w_wr_ok && i_req.word_sel == SEL_DUR),
        .i_waddr(w_addr16[IW-1:0]), .i_wdata(i_req.write_data[15:0]),
        .i_raddr(w_raddr), .o_rdata(w_rd_dur)
    );
    sss_ram #(.WIDTH(32), .DEPTH(STEP_DEPTH)) u_ram_drive (
        .i_clk(i_clk), .i_we(w_wr_ok && i_req.word_sel == SEL_DRIVE),
        .i_waddr(w_addr16[IW-1:0]), .i_wdata(i_req.write_data),
        .i_raddr(w_raddr), .o_rdata(w_rd_drive)
    );
    sss_ram #(.WIDTH(32), .DEPTH(STEP_DEPTH)) u_ram_div (
        .i_clk(i_clk), .i_we(w_wr_ok && i_req.word_sel == SEL_DIV),
        .i_waddr(w_addr16[IW-1:0]), .i_wdata(i_req.write_data),
        .i_raddr(w_raddr), .o_rdata(w_rd_div)
    );

    // Trigger match and timeout of the current step
    assign w_hits = (r_last_sample[DI_COUNT-1:0] ^ w_rd_targ) & w_rd_mask;
    always_comb begin
        case (w_rd_jump[17:16])
            LOGIC_NONE: w_trig = 1'b0;
            LOGIC_OR:   w_trig = |w_hits;
            default:    w_trig = (|w_rd_mask) && (w_hits == w_rd_mask);
        endcase
    end
    assign w_timeout = r_is_tick && (w_rd_dur != 16'd0) && (r_elapsed >= w_rd_dur);
    assign w_end     = w_timeout || (!r_is_tick && w_trig);

    // Jump decode, different for timeout and trigger
    assign w_jump = signed'(w_rd_jump[15:0]);
    always_comb begin
        if (w_jump > 16'sd0) begin
            w_next = 16'(w_jump) - 16'd1;
        end else if ((!r_is_tick && w_jump == JMP_MINUS_ONE)
                     || (r_is_tick && w_jump == JMP_MINUS_TWO)) begin
            w_next = w_total;
        end else begin
            w_next = w_cur16 + 16'd1;
        end
    end

    assign o_stat.running  = r_running;
    assign o_stat.step_end = w_end;
    assign o_stat.enter_ok = w_enter_ok;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_total   <= '0;
            r_repeat_total <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STEP_TOTAL:   r_step_total   <= i_cfg_data[4:0];
                CFG_REPEAT_TOTAL: r_repeat_total <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur         <= '0;
            r_repeats     <= '0;
            r_running     <= 1'b0;
            r_elapsed     <= '0;
            r_last_sample <= '1;
            r_is_tick     <= 1'b0;
            r_next        <= '0;
        end else begin
            if (i_cmd.take) begin
                r_is_tick <= (i_req.req_type == REQ_TICK);
                case (i_req.req_type)
                    REQ_START: begin
                        r_cur     <= '0;
                        r_repeats <= r_repeat_total;
                        r_running <= 1'b1;
                        r_next    <= '0;
                    end
                    REQ_TICK: begin
                        if (r_running && r_elapsed != 16'hFFFF) begin
                            r_elapsed <= r_elapsed + 16'd1;
                        end
                    end
                    REQ_SAMPLE: r_last_sample <= i_req.di_sample;
                    REQ_QUIT:   r_running <= 1'b0;
                    default: ;
                endcase
            end
            if (i_cmd.eval) begin
                r_next <= w_next;
            end
            if (i_cmd.enter) begin
                if (w_in_range) begin
                    r_cur     <= r_next[IW-1:0];
                    r_elapsed <= '0;
                end else if (w_can_wrap) begin
                    r_repeats <= r_repeats - 8'd1;
                    r_cur     <= '0;
                    r_elapsed <= '0;
                end else begin
                    // Repeats spent, or nothing to repeat over
                    if (r_repeat_total != 8'd0) begin
                        r_repeats <= '0;
                    end
                    r_running <= 1'b0;
                end
            end
        end
    end

    // Result strobe: record, finish or applied word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (i_cmd.eval && w_end) || (i_cmd.enter && !w_enter_ok) || i_cmd.apply;
        end
    end

    // Build the next result word
    always_comb begin
        n_res = r_res;
        if (i_cmd.eval && w_end) begin
            n_res               = '0;
            n_res.item_kind     = KIND_RECORD;
            n_res.step_number   = 5'(w_cur16 + 16'd1);
            n_res.was_triggered = !r_is_tick;
            n_res.elapsed_ms    = r_is_tick ? w_rd_dur : r_elapsed;
            n_res.di_snapshot   = r_last_sample;
        end else if (i_cmd.enter && !w_enter_ok) begin
            n_res             = '0;
            n_res.item_kind   = KIND_FINISH;
            n_res.step_number = 5'(w_cur16 + 16'd1);
            n_res.last        = 1'b1;
        end else if (i_cmd.apply) begin
            n_res             = '0;
            n_res.item_kind   = KIND_APPLIED;
            n_res.step_number = 5'(w_cur16 + 16'd1);
            n_res.drive_word  = {w_rd_drive[31:1], 1'b0};
            n_res.drive_valid = w_rd_drive[0];
            n_res.freq_div    = w_rd_div;
            n_res.last        = 1'b1;
        end
    end

    // Result word
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* rtl/core/state_sequence_stepper.sv */
// ----------------------------------------------------------------------------
// state_sequence_stepper
// Table-driven step sequencer with ms timing and digital input triggers.
//
//   channel   signals                             flow control
//   request   i_start / o_busy, i_req             taken when start & !busy
//   result    o_done, o_res                       one cycle, no stall
//   config    i_cfg_valid / o_cfg_ready, index    ready always high
//
// A table write, a quit or an event while stopped uses the idle state
// alone; an evaluated event adds evaluate, and one that ends a step adds
// evaluate, enter and apply (no apply when the sequence finishes), as the
// step table read is registered. A start uses enter and apply, no apply
// when it finishes at once. Reset clears all control state; the step table
// is not cleared and must be written before use. Results are never held.
// ----------------------------------------------------------------------------
module state_sequence_stepper #(
    parameter int STEP_DEPTH = 16,
    parameter int DI_COUNT   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  sss_pkg::t_req  i_req,
    output logic          o_done,
    output sss_pkg::t_res  o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [7:0]    i_cfg_data
);
    import sss_pkg::*;

    `include "assert_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (busy)
    );

    sss_dpath #(.STEP_DEPTH(STEP_DEPTH), .DI_COUNT(DI_COUNT)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_done      (o_done),
        .o_res       (o_res)
    );

    // A record is followed by a finish word or by the apply phase
    `ASSERT_NEXT(a_record_then_more, i_clk, i_rst_n,
        o_done && o_res.item_kind == KIND_RECORD, o_done || busy)
    // The last word of a request leaves the block idle
    `ASSERT_SAME(a_last_idle, i_clk, i_rst_n, o_done && o_res.last, !busy)
    // A record never carries the last flag
    `ASSERT_SAME(a_record_not_last, i_clk, i_rst_n,
        o_done && o_res.item_kind == KIND_RECORD, !o_res.last)

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the step sequencer: a queue-fed driver issues
// requests, a shadow sequencer predicts every result word, and a monitor
// compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import sss_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_done;
    t_res        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_STEP_TOTAL;
    logic [7:0]  i_cfg_data = '0;

    state_sequence_stepper u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req(i_req), .o_done(o_done), .o_res(o_res),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_req req_fifo[$];
    t_res result_fifo[$];
    int   idle_pct = 0;
    bit   failed = 1'b0;

    // Shadow sequencer state
    logic [15:0] sh_jump[16];
    logic [1:0]  sh_logic[16];
    logic [31:0] sh_mask[16];
    logic [31:0] sh_tgt[16];
    logic [15:0] sh_dur[16];
    logic [31:0] sh_drv[16];
    logic        sh_dok[16];
    logic [31:0] sh_div[16];
    int unsigned sh_cur = 0;
    int unsigned sh_reps = 0;
    bit          sh_run = 1'b0;
    int unsigned sh_elapsed = 0;
    logic [31:0] sh_sample = '1;
    logic [4:0]  sh_steps = '0;
    logic [7:0]  sh_repeat = '0;

    // Generator's own copy of the written targets, used to aim samples
    logic [31:0] gen_tgt[16];

    function automatic int unsigned steps_in_use();
        return (sh_steps > 16) ? 16 : sh_steps;
    endfunction

    task automatic enter_at(input int unsigned idx);
        int unsigned total;
        t_res w;
        total = steps_in_use();
        w = '0;
        while (idx >= total) begin
            if (sh_repeat > 0 && sh_reps > 0) begin
                sh_reps--;
                if (total > 0) idx = 0;
            end else begin
                sh_run = 1'b0;
                w.item_kind = KIND_FINISH;
                w.step_number = 5'(sh_cur + 1);
                result_fifo.push_back(w);
                return;
            end
        end
        sh_cur = idx;
        sh_elapsed = 0;
        w.item_kind = KIND_APPLIED;
        w.step_number = 5'(idx + 1);
        w.drive_word = sh_drv[idx];
        w.drive_valid = sh_dok[idx];
        w.freq_div = sh_div[idx];
        result_fifo.push_back(w);
    endtask

    task automatic close_step(input bit trig, input int unsigned el);
        int j;
        int unsigned nxt;
        t_res w;
        w = '0;
        j = int'($signed(sh_jump[sh_cur]));
        w.item_kind = KIND_RECORD;
        w.step_number = 5'(sh_cur + 1);
        w.was_triggered = trig;
        w.elapsed_ms = 16'(el);
        w.di_snapshot = sh_sample;
        result_fifo.push_back(w);
        if (j > 0) nxt = j - 1;
        else if ((trig && j == -1) || (!trig && j == -2)) nxt = steps_in_use();
        else nxt = sh_cur + 1;
        enter_at(nxt);
    endtask

    // Advance the shadow sequencer by one accepted request word
    task automatic sequence_advance(input t_req r);
        int n0;
        logic [31:0] m;
        logic [31:0] hits;
        bit trig;
        n0 = result_fifo.size();
        trig = 1'b0;
        case (r.req_type)
            REQ_WRITE: begin
                if (!sh_run) begin
                    case (r.word_sel)
                        SEL_JUMP: begin
                            sh_jump[r.entry_addr] = r.write_data[15:0];
                            sh_logic[r.entry_addr] = r.write_data[17:16];
                        end
                        SEL_MASK:   sh_mask[r.entry_addr] = r.write_data;
                        SEL_TARGET: sh_tgt[r.entry_addr] = r.write_data;
                        SEL_DUR:    sh_dur[r.entry_addr] = r.write_data[15:0];
                        SEL_DRIVE: begin
                            sh_drv[r.entry_addr] = {r.write_data[31:1], 1'b0};
                            sh_dok[r.entry_addr] = r.write_data[0];
                        end
                        SEL_DIV:    sh_div[r.entry_addr] = r.write_data;
                        default: ;
                    endcase
                end
            end
            REQ_START: begin
                sh_cur = 0;
                sh_reps = sh_repeat;
                sh_run = 1'b1;
                enter_at(0);
            end
            REQ_TICK: begin
                if (sh_run) begin
                    if (sh_elapsed < 65535) sh_elapsed++;
                    if (sh_dur[sh_cur] != 0 && sh_elapsed >= sh_dur[sh_cur])
                        close_step(1'b0, sh_dur[sh_cur]);
                end
            end
            REQ_SAMPLE: begin
                sh_sample = r.di_sample;
                if (sh_run) begin
                    m = sh_mask[sh_cur];
                    hits = (r.di_sample ^ sh_tgt[sh_cur]) & m;
                    if (sh_logic[sh_cur] == LOGIC_OR) trig = (hits != 0);
                    else if (sh_logic[sh_cur] != LOGIC_NONE) trig = (m != 0) && (hits == m);
                    if (trig) close_step(1'b1, sh_elapsed);
                end
            end
            REQ_QUIT: sh_run = 1'b0;
            default: ;
        endcase
        if (result_fifo.size() > n0) result_fifo[$].last = 1'b1;
    endtask

    // Drive the next request word at the falling edge, idling at random
    always @(negedge i_clk) begin
        start <= i_rst_n && req_fifo.size() > 0 && ($urandom_range(99) >= idle_pct);
        if (req_fifo.size() > 0) i_req <= req_fifo[0];
    end

    // Take accepted words, track config writes and check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_STEP_TOTAL) sh_steps = i_cfg_data[4:0];
                else if (i_cfg_index == CFG_REPEAT_TOTAL) sh_repeat = i_cfg_data;
            end
            if (o_done) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, o_res);
                    failed = 1'b1;
                end else begin
                    if (o_res !== result_fifo[0]) begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $time, result_fifo[0], o_res);
                        failed = 1'b1;
                    end
                    void'(result_fifo.pop_front());
                end
            end
            if (start && !busy) begin
                sequence_advance(i_req);
                void'(req_fifo.pop_front());
            end
        end
    end

    function automatic t_req mk(input logic [2:0] rt, input logic [3:0] a,
                                input logic [2:0] s, input logic [31:0] d,
                                input logic [31:0] smp);
        t_req r;
        r.req_type = rt; r.entry_addr = a; r.word_sel = s;
        r.write_data = d; r.di_sample = smp;
        return r;
    endfunction

    // Request of the given type with random payload
    function automatic t_req rnd_req(input logic [2:0] rt);
        return mk(rt, 4'($urandom), 3'($urandom), $urandom, $urandom);
    endfunction

    function automatic logic [31:0] rnd_word(input logic [2:0] s, input logic [3:0] a);
        logic [15:0] j;
        logic [31:0] d;
        d = $urandom;
        case (s)
            SEL_JUMP: begin
                case ($urandom_range(5))
                    0: j = 16'd0;
                    1: j = JMP_MINUS_ONE;
                    2: j = JMP_MINUS_TWO;
                    3: j = 16'($urandom_range(1, 18));
                    4: j = 16'($urandom_range(16'h8000, 16'hFFFD));
                    default: j = 16'($urandom);
                endcase
                d[15:0] = j;
            end
            SEL_MASK: begin
                case ($urandom_range(3))
                    0: d = '0;
                    1: d = '1;
                    default: d = $urandom & $urandom & $urandom;
                endcase
            end
            SEL_DUR: begin
                if ($urandom_range(49) == 0) d[15:0] = 16'hFFFF;
                else d[15:0] = 16'($urandom_range(0, 6));
            end
            default: ;
        endcase
        if (s == SEL_TARGET) gen_tgt[a] = d;
        return d;
    endfunction

    function automatic logic [31:0] rnd_sample();
        case ($urandom_range(4))
            0: return $urandom;
            1: return '0;
            2: return '1;
            default: return ~gen_tgt[$urandom_range(15)] ^ ($urandom & $urandom & $urandom);
        endcase
    endfunction

    task automatic push_write(input logic [3:0] a, input logic [2:0] s);
        req_fifo.push_back(mk(REQ_WRITE, a, s, rnd_word(s, a), $urandom));
    endtask

    // Fill the queue with a reload, a start and a run of events
    task automatic queue_run(input int events);
        int k;
        req_fifo.push_back(rnd_req(REQ_QUIT));
        repeat ($urandom_range(2, 10))
            push_write(4'($urandom), 3'($urandom_range(5)));
        req_fifo.push_back(rnd_req(REQ_START));
        for (k = 0; k < events; k++) begin
            case ($urandom_range(99)) inside
                [0:59]:  req_fifo.push_back(rnd_req(REQ_TICK));
                [60:89]: req_fifo.push_back(mk(REQ_SAMPLE, 4'($urandom), 3'($urandom),
                                               $urandom, rnd_sample()));
                [90:92]: req_fifo.push_back(rnd_req(REQ_START));
                [93:94]: req_fifo.push_back(rnd_req(REQ_QUIT));
                [95:97]: req_fifo.push_back(rnd_req(REQ_WRITE));
                default: req_fifo.push_back(rnd_req(3'($urandom_range(5, 7))));
            endcase
        end
    endtask

    task automatic drain();
        while (req_fifo.size() != 0 || result_fifo.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int a;
        int s;
        int ph;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load every word of every entry so no read hits an unwritten entry
        cfg_write(CFG_STEP_TOTAL, 8'd16);
        cfg_write(CFG_REPEAT_TOTAL, 8'd1);
        for (a = 0; a < 16; a++)
            for (s = 0; s <= 5; s++) push_write(4'(a), 3'(s));
        drain();

        // Directed: ignored word selects, unknown requests, idle events
        req_fifo.push_back(mk(REQ_WRITE, 4'd3, 3'd6, '1, '0));
        req_fifo.push_back(mk(REQ_WRITE, 4'd3, 3'd7, '1, '0));
        req_fifo.push_back(mk(3'd7, '1, '1, '1, '1));
        req_fifo.push_back(mk(REQ_TICK, '0, '0, '0, '0));
        req_fifo.push_back(mk(REQ_SAMPLE, '0, '0, '0, '0));
        req_fifo.push_back(mk(REQ_START, '0, '0, '0, '0));
        repeat (8) req_fifo.push_back(mk(REQ_TICK, '0, '0, '0, '0));
        req_fifo.push_back(mk(REQ_SAMPLE, '0, '0, '0, '1));
        req_fifo.push_back(mk(REQ_SAMPLE, '0, '0, '0, '0));
        req_fifo.push_back(mk(REQ_START, '1, '1, '1, '1));
        req_fifo.push_back(mk(REQ_QUIT, '0, '0, '0, '0));
        drain();

        // Directed: a step with no timeout, then an AND trigger on input bit 0
        cfg_write(CFG_STEP_TOTAL, 8'd1);
        cfg_write(CFG_REPEAT_TOTAL, 8'd0);
        req_fifo.push_back(mk(REQ_WRITE, 4'd0, SEL_JUMP, 32'h0002_FFFF, '0));
        req_fifo.push_back(mk(REQ_WRITE, 4'd0, SEL_MASK, 32'h1, '0));
        req_fifo.push_back(mk(REQ_WRITE, 4'd0, SEL_TARGET, 32'h1, '0));
        req_fifo.push_back(mk(REQ_WRITE, 4'd0, SEL_DUR, 32'h0, '0));
        gen_tgt[0] = 32'h1;
        req_fifo.push_back(mk(REQ_START, '0, '0, '0, '0));
        repeat (20) req_fifo.push_back(mk(REQ_TICK, '0, '0, '0, '0));
        req_fifo.push_back(mk(REQ_SAMPLE, '0, '0, '0, '1));
        req_fifo.push_back(mk(REQ_SAMPLE, '0, '0, '0, 32'hFFFF_FFFE));
        drain();

        // Random phases across settings and idle rates
        for (ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: idle_pct = 0;
                1: idle_pct = 64;
                default: idle_pct = 10;
            endcase
            case (ph)
                0: begin cfg_write(CFG_STEP_TOTAL, 8'd0); cfg_write(CFG_REPEAT_TOTAL, 8'd3); end
                1: begin cfg_write(CFG_STEP_TOTAL, 8'hFF); cfg_write(CFG_REPEAT_TOTAL, 8'hFF); end
                2: begin cfg_write(CFG_STEP_TOTAL, 8'd1); cfg_write(CFG_REPEAT_TOTAL, 8'd0); end
                default: begin
                    cfg_write(CFG_STEP_TOTAL, 8'($urandom));
                    cfg_write(CFG_REPEAT_TOTAL, 8'($urandom_range(0, 4)));
                end
            endcase
            repeat (4) queue_run(40);
            drain();
        end

        if (!failed)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Stop a hung run
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
